// ===== sv/bgu4_pkg.sv =====
// ----------------------------------------------------------------------------
// bgu4_pkg
// Shared types and constants for the bilinear grid upsampler by four.
// ----------------------------------------------------------------------------
package bgu4_pkg;

  // Configuration register width and index width.
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Fine grid coordinates are fixed at eight bits.
  localparam int unsigned COORD_W = 8;

  // Coarse rows per frame are limited to 64.
  localparam int unsigned ROW_LIMIT = 64;
  localparam int unsigned ROW_W     = 6;

  // Quarter steps run from 1 to 4; weights are products of two steps.
  localparam int unsigned STEP_W = 3;
  localparam int unsigned WT_W   = 5;
  localparam logic [STEP_W-1:0] STEP_FIRST = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LAST  = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COARSE_COLS = 1'b0,
    CFG_COARSE_ROWS = 1'b1
  } cfg_idx_e;

  // Position of the coarse sample that closes a patch.
  typedef struct packed {
    logic [COORD_W-1:0] base_col;
    logic [COORD_W-1:0] base_row;
    logic               col_first;
    logic               row_first;
  } pos_t;

endpackage

// ===== sv/bilinear_grid_upsample_by_four_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_grid_upsample_by_four_top
// Bilinear upsampler by four: coarse grid samples in, fine grid points out.
// ----------------------------------------------------------------------------
// Coarse samples enter on the slave stream in raster order. Each sample
// closes a patch of fine points between it and its left and upper
// neighbours: one point at the first row and column, four along the first
// row or column, sixteen elsewhere. The points leave on the master stream in
// raster order within the patch, tlast marking the last point of the patch.
// The first point of a patch goes from the patch register, loaded on its
// sample's beat, into the result register. One fine point leaves per cycle
// while the receiver does not stall, a pace set by the single result
// register, which takes one point of the patch register in each cycle that
// it is free. A new sample is accepted in the same cycle as the previous
// patch's last point enters the result register: no bubble between patches.
// Reset returns the position to row 0, column 0 and both size registers to
// 12; the line buffer is not cleared and needs no clearing pass. When the
// receiver stalls, the result register holds its point and the patch
// register waits, and the slave stream stalls once a patch is pending.
// The user writes size registers only while idle; the block won't enforce it.
// ----------------------------------------------------------------------------
module bilinear_grid_upsample_by_four_top #(
  parameter int unsigned MAX_COARSE_COLS = 64,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [bgu4_pkg::CFG_IDX_W-1:0]               cfg_idx_i,
  input  logic [bgu4_pkg::CFG_W-1:0]                   cfg_data_i,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // sample, zero padded to whole bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]             s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // fine_col, fine_row, value, zero padded to whole bytes
  output logic [((2*bgu4_pkg::COORD_W+SAMPLE_BITS+4+7)/8)*8-1:0] m_axis_tdata,
  output logic                                        m_axis_tlast
);
  import bgu4_pkg::*;

  localparam int unsigned VW     = SAMPLE_BITS + 4;
  localparam int unsigned OUT_W  = ((2 * COORD_W + VW + 7) / 8) * 8;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] a, b, c;
  pos_t                   pos;
  logic [COORD_W-1:0]     fine_col, fine_row;
  logic [VW-1:0]          value;

  assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;

  bgu4_front #(
    .MAX_COARSE_COLS (MAX_COARSE_COLS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .sample_i   (sample),
    .a_o        (a),
    .b_o        (b),
    .c_o        (c),
    .pos_o      (pos)
  );

  bgu4_emit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .a_i         (a),
    .b_i         (b),
    .c_i         (c),
    .d_i         (sample),
    .pos_i       (pos),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .fine_col_o  (fine_col),
    .fine_row_o  (fine_row),
    .value_o     (value),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({value, fine_row, fine_col});

`ifndef SYNTH
  // The last point of a patch is the one on the coarse sample itself, which
  // sits at a multiple of four in both directions; no other point does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == ((fine_col[1:0] == 2'd0) && (fine_row[1:0] == 2'd0))))
    else $error("tlast does not match the patch corner position");

  // Once a point that is not the last of its patch is taken, the next point
  // of that patch must follow at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("patch run broken after a non-final point");

  // No new sample is taken while a point that is not the last of its patch
  // is held in the result register by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast && !m_axis_tready) |-> !s_axis_tready)
    else $error("sample accepted with a patch still in progress");
`endif

endmodule

// ===== sv/bgu4_front.sv =====
// ----------------------------------------------------------------------------
// bgu4_front
// Configuration registers, coarse position counters, line buffer and the
// left-hand samples that complete the four corners of each patch.
// ----------------------------------------------------------------------------
module bgu4_front #(
  parameter int unsigned MAX_COARSE_COLS = 64,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bgu4_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgu4_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          accept_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  output logic [SAMPLE_BITS-1:0]        a_o,
  output logic [SAMPLE_BITS-1:0]        b_o,
  output logic [SAMPLE_BITS-1:0]        c_o,
  output bgu4_pkg::pos_t                pos_o
);
  import bgu4_pkg::*;

  localparam int unsigned COL_W = (MAX_COARSE_COLS > 1) ? $clog2(MAX_COARSE_COLS) : 1;
  localparam int unsigned LIM_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam logic [LIM_W-1:0] COL_MAX = LIM_W'(MAX_COARSE_COLS);
  localparam logic [LIM_W-1:0] LIM_MIN = LIM_W'(2);
  localparam logic [CFG_W-1:0] ROW_MAX = CFG_W'(ROW_LIMIT);
  localparam logic [CFG_W-1:0] ROW_MIN = CFG_W'(2);

  logic [CFG_W-1:0]       cols_q, rows_q;
  logic [COL_W-1:0]       col_q, col_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [SAMPLE_BITS-1:0] left_q, left_above_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0] mem [MAX_COARSE_COLS];
  logic [LIM_W-1:0]       cols_ext, cols_eff;
  logic [CFG_W-1:0]       rows_eff;
  logic [COL_W-1:0]       rd_addr;
  logic [SAMPLE_BITS-1:0] b_eff;
  logic                   col_wrap, row_wrap;

  always_comb begin
    cols_ext = LIM_W'(cols_q);
    if (cols_ext < LIM_MIN) begin
      cols_eff = LIM_MIN;
    end else if (cols_ext > COL_MAX) begin
      cols_eff = COL_MAX;
    end else begin
      cols_eff = cols_ext;
    end
    if (rows_q < ROW_MIN) begin
      rows_eff = ROW_MIN;
    end else if (rows_q > ROW_MAX) begin
      rows_eff = ROW_MAX;
    end else begin
      rows_eff = rows_q;
    end

    col_wrap = (LIM_W'(col_q) + LIM_W'(1)) >= cols_eff;
    row_wrap = (CFG_W'(row_q) + CFG_W'(1)) >= rows_eff;

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end

    // Read ahead at the position of the next sample, so that the registered
    // read data is ready when it arrives.
    rd_addr = accept_i ? col_d : col_q;

    // The top coarse row has nothing above it; its weight is zero there.
    b_eff = (row_q == '0) ? '0 : rd_q;
  end

  assign a_o = left_above_q;
  assign b_o = b_eff;
  assign c_o = left_q;

  always_comb begin
    pos_o.base_col  = COORD_W'(col_q) << 2;
    pos_o.base_row  = COORD_W'(row_q) << 2;
    pos_o.col_first = (col_q == '0);
    pos_o.row_first = (row_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q       <= CFG_W'(12);
      rows_q       <= CFG_W'(12);
      col_q        <= '0;
      row_q        <= '0;
      left_q       <= '0;
      left_above_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COARSE_COLS: cols_q <= cfg_data_i;
          CFG_COARSE_ROWS: rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      if (accept_i) begin
        left_q       <= sample_i;
        left_above_q <= b_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[col_q] <= sample_i;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

// ===== sv/bgu4_emit.sv =====
// ----------------------------------------------------------------------------
// bgu4_emit
// Holds one patch of four coarse corners and walks its fine points, one
// interpolated value into the result register per cycle while it is free.
// ----------------------------------------------------------------------------
module bgu4_emit #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        a_i,
  input  logic [SAMPLE_BITS-1:0]        b_i,
  input  logic [SAMPLE_BITS-1:0]        c_i,
  input  logic [SAMPLE_BITS-1:0]        d_i,
  input  bgu4_pkg::pos_t                pos_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bgu4_pkg::COORD_W-1:0]  fine_col_o,
  output logic [bgu4_pkg::COORD_W-1:0]  fine_row_o,
  output logic [SAMPLE_BITS+3:0]        value_o,
  output logic                          last_o
);
  import bgu4_pkg::*;

  localparam int unsigned VW = SAMPLE_BITS + 4;

  logic                   busy_q;
  logic [SAMPLE_BITS-1:0] a_q, b_q, c_q, d_q;
  pos_t                   pos_q;
  logic [STEP_W-1:0]      j_q, k_q, j_nxt, k_nxt;
  logic                   out_valid_q;
  logic [COORD_W-1:0]     col_out_q, row_out_q;
  logic [VW-1:0]          value_q;
  logic                   last_q;

  logic                   out_load, step, last_pt, accept;
  logic [STEP_W-1:0]      wj, wk;
  logic [WT_W-1:0]        wa, wb, wc, wd;
  logic [VW-1:0]          value_d;
  logic [COORD_W-1:0]     col_d, row_d;

  always_comb begin
    out_load = !out_valid_q || out_ready_i;
    step     = busy_q && out_load;
    last_pt  = (j_q == STEP_LAST) && (k_q == STEP_LAST);
    in_ready_o = !busy_q || (step && last_pt);
    accept   = in_valid_i && in_ready_o;

    if (j_q == STEP_LAST) begin
      j_nxt = pos_q.col_first ? STEP_LAST : STEP_FIRST;
      k_nxt = k_q + STEP_W'(1);
    end else begin
      j_nxt = j_q + STEP_W'(1);
      k_nxt = k_q;
    end

    wj = STEP_LAST - j_q;
    wk = STEP_LAST - k_q;
    wa = WT_W'(wk) * WT_W'(wj);
    wb = WT_W'(wk) * WT_W'(j_q);
    wc = WT_W'(k_q) * WT_W'(wj);
    wd = WT_W'(k_q) * WT_W'(j_q);
    value_d = VW'(a_q) * VW'(wa) + VW'(b_q) * VW'(wb)
            + VW'(c_q) * VW'(wc) + VW'(d_q) * VW'(wd);

    col_d = pos_q.base_col + COORD_W'(j_q) - COORD_W'(STEP_LAST);
    row_d = pos_q.base_row + COORD_W'(k_q) - COORD_W'(STEP_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      j_q         <= STEP_FIRST;
      k_q         <= STEP_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        j_q    <= pos_i.col_first ? STEP_LAST : STEP_FIRST;
        k_q    <= pos_i.row_first ? STEP_LAST : STEP_FIRST;
      end else if (step) begin
        busy_q <= !last_pt;
        j_q    <= j_nxt;
        k_q    <= k_nxt;
      end
      if (out_load) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= a_i;
      b_q   <= b_i;
      c_q   <= c_i;
      d_q   <= d_i;
      pos_q <= pos_i;
    end
    if (step) begin
      col_out_q <= col_d;
      row_out_q <= row_d;
      value_q   <= value_d;
      last_q    <= last_pt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fine_col_o  = col_out_q;
  assign fine_row_o  = row_out_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// ===== verif/tb_bilinear_grid_upsample_by_four_top.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_grid_upsample_by_four_top
// Self-checking bench for the bilinear grid upsampler by four.
// ----------------------------------------------------------------------------
// Coarse samples go in on the slave stream. Every fine point that the block
// should emit is worked out in the bench and queued at the time its sample is
// offered. Each beat on the master stream is checked field by field against
// the head of that queue. A short table of hand-picked samples and size
// settings comes first: range extremes, size changes in the middle of a
// frame, and frame wrap. Random phases follow, with different sizes and
// idling mixes on both streams, one long receiver hold-off and one pause of
// the sender until the queue runs dry.
// ----------------------------------------------------------------------------
module tb_bilinear_grid_upsample_by_four_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bgu4_pkg::*;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned VALUE_W     = SAMPLE_W + 4;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned IN_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((2 * COORD_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 4;
  localparam logic [7:0]  SIZE_RANDOM = 8'hFF;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [VALUE_W-1:0] value;
    logic               last;
  } fine_pt_t;

  typedef enum logic {ROW_ITEM, ROW_SIZES} row_kind_e;

  // Directed row: either a size write or a sample. Where the last point of
  // the patch is obvious (sixteen times the sample, at four times the
  // position) it is typed in and replaces the computed one.
  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_W-1:0]   cols;
    logic [CFG_W-1:0]   rows;
    logic [SAMPLE_W-1:0] sample;
    logic               known;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [VALUE_W-1:0] value;
  } dir_row_t;

  localparam dir_row_t DIRECTED [27] = '{
    '{ROW_ITEM,  7'd0,   7'd0,   16'h0000, 1'b1, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hFFFF, 1'b1, 8'd4,  8'd0, 20'hFFFF0},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hAAAA, 1'b1, 8'd8,  8'd0, 20'hAAAA0},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h5555, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h0001, 1'b0, 8'd0,  8'd0, 20'h00000},
    // Width below range, and the position already past the new last column.
    '{ROW_SIZES, 7'd1,   7'd12,  16'h0000, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h8000, 1'b1, 8'd20, 8'd0, 20'h80000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h0001, 1'b1, 8'd0,  8'd4, 20'h00010},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h7FFF, 1'b0, 8'd0,  8'd0, 20'h00000},
    // Height below range while already on the third row.
    '{ROW_SIZES, 7'd1,   7'd1,   16'h0000, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h1234, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hFEDC, 1'b1, 8'd4,  8'd8, 20'hFEDC0},
    // New frame: no rows above, a single point.
    '{ROW_ITEM,  7'd0,   7'd0,   16'hFFFF, 1'b1, 8'd0,  8'd0, 20'hFFFF0},
    '{ROW_SIZES, 7'd127, 7'd127, 16'h0000, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h0F0F, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hF0F0, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h00FF, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hFF00, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_SIZES, 7'd2,   7'd2,   16'h0000, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h3C3C, 1'b1, 8'd20, 8'd0, 20'h3C3C0},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hFFFF, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h0000, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hFFFF, 1'b1, 8'd0,  8'd0, 20'hFFFF0},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h0000, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'hC3A5, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h5A3C, 1'b0, 8'd0,  8'd0, 20'h00000},
    '{ROW_ITEM,  7'd0,   7'd0,   16'h9669, 1'b0, 8'd0,  8'd0, 20'h00000}
  };

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic [7:0] count;
    logic [6:0] tx_pct;
    logic [6:0] rx_pct;
    logic       hold;
    logic       pause;
  } phase_t;

  localparam phase_t PHASES [8] = '{
    '{8'd64,       8'd2,        8'd66, 7'd0,  7'd0,  1'b0, 1'b0},
    '{8'd2,        8'd64,       8'd12, 7'd46, 7'd0,  1'b0, 1'b0},
    '{8'd0,        8'd127,      8'd10, 7'd0,  7'd46, 1'b0, 1'b0},
    '{SIZE_RANDOM, SIZE_RANDOM, 8'd10, 7'd31, 7'd31, 1'b0, 1'b0},
    '{SIZE_RANDOM, 8'd65,       8'd10, 7'd0,  7'd0,  1'b1, 1'b0},
    '{8'd1,        SIZE_RANDOM, 8'd10, 7'd46, 7'd0,  1'b0, 1'b1},
    '{8'd127,      8'd1,        8'd10, 7'd0,  7'd46, 1'b0, 1'b0},
    '{SIZE_RANDOM, SIZE_RANDOM, 8'd10, 7'd31, 7'd31, 1'b0, 1'b0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // sample
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // fine_col, fine_row, value, zero padding
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;

  // Model of the block's state and size registers.
  logic [SAMPLE_W-1:0] row_above [MAX_COLS];
  logic [SAMPLE_W-1:0] left_s;
  logic [SAMPLE_W-1:0] left_above_s;
  int unsigned         col_pos;
  int unsigned         row_pos;
  int unsigned         buf_filled;
  logic [CFG_W-1:0]    cols_reg;
  logic [CFG_W-1:0]    rows_reg;

  fine_pt_t    pending_pts [$];
  int unsigned tx_pct;
  int unsigned rx_pct;
  logic        hold_tgl;
  logic        hold_seen;
  int unsigned hold_left;
  int unsigned fail_cnt;
  int unsigned samples_sent;
  int unsigned points_seen;
  int unsigned size_writes;
  int unsigned input_stalls;
  int unsigned quiet_cycles;

  bilinear_grid_upsample_by_four_top #(
    .MAX_COARSE_COLS(MAX_COLS),
    .SAMPLE_BITS    (SAMPLE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned span(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Queues the points of the patch that sample d closes, then moves the
  // position on. The patch spans from just after the previous coarse row and
  // column up to the sample itself.
  task automatic predict_patch(input logic [SAMPLE_W-1:0] d);
    fine_pt_t            pt;
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] c;
    int unsigned         k;
    int unsigned         j;
    int unsigned         k0;
    int unsigned         j0;
    a  = left_above_s;
    b  = row_above[col_pos];
    c  = left_s;
    k0 = (row_pos == 0) ? 4 : 1;
    j0 = (col_pos == 0) ? 4 : 1;
    for (k = k0; k <= 4; k++) begin
      for (j = j0; j <= 4; j++) begin
        pt.col   = COORD_W'(4 * col_pos + j - 4);
        pt.row   = COORD_W'(4 * row_pos + k - 4);
        pt.value = VALUE_W'((4 - k) * (4 - j) * a + (4 - k) * j * b
                            + k * (4 - j) * c + k * j * d);
        pt.last  = (k == 4) && (j == 4);
        pending_pts.push_back(pt);
      end
    end
    left_above_s     = b;
    left_s           = d;
    row_above[col_pos] = d;
    if (col_pos + 1 > buf_filled) buf_filled = col_pos + 1;
    if (col_pos + 1 >= span(cols_reg, MAX_COLS)) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= span(rows_reg, ROW_LIMIT)) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // Lowers valid and waits until every queued point has left the block.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    logic [CFG_W-1:0] c;
    c = cols;
    // Below the first row a wider frame would read line buffer entries that
    // have never been written, so the width is held to what has been filled.
    if (row_pos != 0 && span(c, MAX_COLS) > buf_filled) c = CFG_W'(buf_filled);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COARSE_COLS;
    cfg_data_i <= c;
    @(posedge clk_i);
    cols_reg    = c;
    cfg_idx_i  <= CFG_COARSE_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    rows_reg    = rows;
    cfg_we_i   <= 1'b0;
    size_writes += 2;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] d, input logic known,
                             input fine_pt_t typed);
    while ($urandom_range(99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(d);
    predict_patch(d);
    if (known) begin
      void'(pending_pts.pop_back());
      pending_pts.push_back(typed);
    end
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    samples_sent++;
  endtask

  // Receiver: random stalls at the phase's rate, plus a long hold-off on
  // request, counted here.
  always @(posedge clk_i) begin
    if (hold_seen != hold_tgl) begin
      hold_seen = hold_tgl;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_pct);
    end
  end

  always @(posedge clk_i) begin
    fine_pt_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready !== 1'b1) input_stalls++;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      points_seen++;
      if (pending_pts.size() == 0) begin
        $error("fine point beat with nothing expected: col %0d row %0d value %0h",
               m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[35:16]);
        fail_cnt++;
      end else begin
        want = pending_pts.pop_front();
        if (m_axis_tdata[7:0] !== want.col) begin
          $error("fine_col: expected %0d, actual %0d", want.col, m_axis_tdata[7:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[15:8] !== want.row) begin
          $error("fine_row: expected %0d, actual %0d", want.row, m_axis_tdata[15:8]);
          fail_cnt++;
        end
        if (m_axis_tdata[35:16] !== want.value) begin
          $error("value: expected %0h, actual %0h", want.value, m_axis_tdata[35:16]);
          fail_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_in_run: expected %0b, actual %0b", want.last, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out: no beat on either stream for %0d cycles.", QUIET_LIMIT);
      $display("bilinear_grid_upsample_by_four_top regression: fail");
      $finish;
    end
  end

  initial begin
    fine_pt_t         typed;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] r;
    int unsigned      n;
    foreach (row_above[i]) row_above[i] = '0;
    left_s       = '0;
    left_above_s = '0;
    col_pos      = 0;
    row_pos      = 0;
    buf_filled   = 0;
    cols_reg     = CFG_W'(12);
    rows_reg     = CFG_W'(12);
    tx_pct       = 0;
    rx_pct       = 0;
    hold_tgl     = 1'b0;
    hold_seen    = 1'b0;
    hold_left    = 0;
    fail_cnt     = 0;
    samples_sent = 0;
    points_seen  = 0;
    size_writes  = 0;
    input_stalls = 0;
    quiet_cycles = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_SIZES) begin
        drain();
        set_sizes(DIRECTED[i].cols, DIRECTED[i].rows);
      end else begin
        typed.col   = DIRECTED[i].col;
        typed.row   = DIRECTED[i].row;
        typed.value = DIRECTED[i].value;
        typed.last  = 1'b1;
        send_sample(DIRECTED[i].sample, DIRECTED[i].known, typed);
      end
    end

    foreach (PHASES[p]) begin
      drain();
      c = (PHASES[p].cols == SIZE_RANDOM) ? CFG_W'($urandom_range(127))
                                          : CFG_W'(PHASES[p].cols);
      r = (PHASES[p].rows == SIZE_RANDOM) ? CFG_W'($urandom_range(127))
                                          : CFG_W'(PHASES[p].rows);
      set_sizes(c, r);
      tx_pct = PHASES[p].tx_pct;
      rx_pct = PHASES[p].rx_pct;
      for (n = 0; n < PHASES[p].count; n++) begin
        // The sender keeps offering through the hold-off, so the block backs up.
        if (PHASES[p].hold && n == 2) hold_tgl = ~hold_tgl;
        if (PHASES[p].pause && n == PHASES[p].count / 2) drain();
        send_sample(pick_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d coarse samples, %0d fine points and %0d size writes,",
             samples_sent, points_seen, size_writes);
    $display("with %0d cycles of input back-pressure across all idling mixes.",
             input_stalls);
    if (fail_cnt == 0) begin
      $display("bilinear_grid_upsample_by_four_top regression: pass");
    end else begin
      $display("bilinear_grid_upsample_by_four_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bgu4_pkg.sv
sv/bgu4_front.sv
sv/bgu4_emit.sv
sv/bilinear_grid_upsample_by_four_top.sv
verif/tb_bilinear_grid_upsample_by_four_top.sv
